// ===== hw/rtl/apu_tone_register_mixer_unit_assert.svh =====
// Assertion macros for the APU tone register mixer unit.
`ifndef APU_TONE_REGISTER_MIXER_UNIT_ASSERT_SVH
`define APU_TONE_REGISTER_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define APU_TRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("apu_trm assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define APU_TRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("apu_trm assertion failed");

`endif

// ===== hw/rtl/apu_trm_pkg.sv =====
// Shared types and constants of the APU tone register mixer unit.
package apu_trm_pkg;

  localparam int unsigned CpuClockHz = 1789773;
  // floor(C / (16 * n)) equals floor(floor(C / 16) / n).
  localparam int unsigned DivNum     = CpuClockHz / 16;
  localparam int unsigned NumW       = $clog2(DivNum + 1);
  localparam int unsigned PerW       = 11;
  localparam int unsigned DvsW       = PerW + 1;
  localparam int unsigned FreqW      = 14;
  localparam int unsigned VolW       = 4;
  localparam int unsigned CntW       = $clog2(NumW);

  localparam logic [FreqW-1:0] FreqCapHz = FreqW'(12000);
  localparam logic [FreqW-1:0] TriMinHz  = FreqW'(100);
  localparam logic [VolW-1:0]  VolOn     = VolW'(15);
  localparam logic [VolW-1:0]  VolTriTone = VolW'(2);
  localparam logic [VolW-1:0]  VolOff    = '0;

  localparam logic [15:0] AddrSq1Ctrl = 16'h4000;
  localparam logic [15:0] AddrSq1Low  = 16'h4002;
  localparam logic [15:0] AddrSq1High = 16'h4003;
  localparam logic [15:0] AddrSq2Ctrl = 16'h4004;
  localparam logic [15:0] AddrSq2Low  = 16'h4006;
  localparam logic [15:0] AddrSq2High = 16'h4007;
  localparam logic [15:0] AddrTriCtrl = 16'h4008;
  localparam logic [15:0] AddrTriLow  = 16'h400A;
  localparam logic [15:0] AddrTriHigh = 16'h400B;
  localparam logic [15:0] AddrEnable  = 16'h4015;

  localparam logic [1:0] ChSq1 = 2'd0;
  localparam logic [1:0] ChSq2 = 2'd1;
  localparam logic [1:0] ChTri = 2'd2;

  typedef struct packed {
    logic            start;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/apu_tone_register_mixer_unit.sv =====
// Top level of the APU tone register mixer unit: register decode, channel state, output.
// Writes other than period high go through the done state into the output register.
// Period high writes first run the shared divider, which yields one quotient bit per cycle.
// Throughput: one transaction at a time; input ready is low until the result is registered.
// Reset clears all periods, frequencies and volumes to zero and empties the output register.
module apu_tone_register_mixer_unit
  import apu_trm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] bus_address, [23:16] write_data
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [13:0] square1_freq, [27:14] square2_freq, [41:28] triangle_freq,
  // [45:42] square1_vol, [49:46] square2_vol, [53:50] triangle_vol, [55:54] zero
  output logic [55:0] m_axis_tdata_o
);

  `include "apu_tone_register_mixer_unit_assert.svh"

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e          state_q;
  logic [1:0]      ch_q;
  logic [7:0]      period_low_q  [3];
  logic [FreqW-1:0] tone_freq_q  [3];
  logic [VolW-1:0] mix_volume_q  [3];
  logic            m_valid_q;
  logic [55:0]     m_data_q;

  logic [15:0]     s_addr;
  logic [7:0]      s_data;
  logic            accept;
  logic            is_ctrl;
  logic            is_low;
  logic            is_high;
  logic            is_en;
  logic [1:0]      dec_ch;
  logic [VolW-1:0] ctrl_vol;
  logic [FreqW-1:0] capped;
  logic [55:0]     packed_out;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_addr          = s_axis_tdata_i[15:0];
  assign s_data          = s_axis_tdata_i[23:16];
  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    is_ctrl = 1'b0;
    is_low  = 1'b0;
    is_high = 1'b0;
    is_en   = 1'b0;
    dec_ch  = ChSq1;
    unique case (s_addr)
      AddrSq1Ctrl: begin is_ctrl = 1'b1; dec_ch = ChSq1; end
      AddrSq2Ctrl: begin is_ctrl = 1'b1; dec_ch = ChSq2; end
      AddrTriCtrl: begin is_ctrl = 1'b1; dec_ch = ChTri; end
      AddrSq1Low:  begin is_low  = 1'b1; dec_ch = ChSq1; end
      AddrSq2Low:  begin is_low  = 1'b1; dec_ch = ChSq2; end
      AddrTriLow:  begin is_low  = 1'b1; dec_ch = ChTri; end
      AddrSq1High: begin is_high = 1'b1; dec_ch = ChSq1; end
      AddrSq2High: begin is_high = 1'b1; dec_ch = ChSq2; end
      AddrTriHigh: begin is_high = 1'b1; dec_ch = ChTri; end
      AddrEnable:  begin is_en   = 1'b1; end
      default: ;
    endcase
  end

  // The triangle control bit is bit zero; square channels use the low nibble.
  assign ctrl_vol = (dec_ch == ChTri) ? (s_data[0] ? VolOn : VolOff)
                                      : ((|s_data[3:0]) ? VolOn : VolOff);

  assign div_req.start   = accept && is_high;
  assign div_req.divisor = DvsW'({s_data[2:0], period_low_q[dec_ch]}) + DvsW'(1);

  apu_trm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign capped = (div_rsp.quotient > NumW'(FreqCapHz)) ? FreqCapHz
                                                         : div_rsp.quotient[FreqW-1:0];

  assign packed_out = {2'b00, mix_volume_q[2], mix_volume_q[1], mix_volume_q[0],
                       tone_freq_q[2], tone_freq_q[1], tone_freq_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ch_q      <= ChSq1;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        period_low_q[i]  <= '0;
        tone_freq_q[i]   <= '0;
        mix_volume_q[i]  <= '0;
      end
    end else begin
      // In the done state the output register is either reloaded or held.
      if (m_axis_tready_i && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            ch_q    <= dec_ch;
            state_q <= is_high ? StDiv : StDone;
            if (is_ctrl) begin
              mix_volume_q[dec_ch] <= ctrl_vol;
            end
            if (is_low) begin
              period_low_q[dec_ch] <= s_data;
            end
            if (is_en) begin
              for (int i = 0; i < 3; i++) begin
                if (!s_data[i]) begin
                  mix_volume_q[i] <= VolOff;
                end
              end
            end
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            tone_freq_q[ch_q] <= capped;
            if (ch_q == ChTri) begin
              mix_volume_q[ch_q] <= (capped < TriMinHz) ? VolOff : VolTriTone;
            end
            state_q <= StDone;
          end
        end
        StDone: begin
          // Wait for the output register to drain before loading the new snapshot.
          if (!m_valid_q || m_axis_tready_i) begin
            m_data_q  <= packed_out;
            m_valid_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `APU_TRM_ASSERT_NOW(a_busy_not_ready, state_q != StIdle, !s_axis_tready_o)
  `APU_TRM_ASSERT_NOW(a_done_only_in_div, div_rsp.done, state_q == StDiv)
  `APU_TRM_ASSERT_NEXT(a_high_starts_div, accept && is_high, state_q == StDiv)
  `APU_TRM_ASSERT_NOW(a_tri_freq_capped, 1'b1, tone_freq_q[2] <= FreqCapHz)

endmodule

// ===== hw/rtl/apu_trm_divider.sv =====
// Radix-2 restoring divider of the fixed numerator, the clock over 16, by the period plus one.
module apu_trm_divider
  import apu_trm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [NumW-1:0] dq_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvsW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DvsW-1:0] rem_shift;
  logic            fits;

  // The remainder stays below the divisor, so the shifted value fits its width.
  assign rem_shift = {rem_q[DvsW-2:0], dq_q[NumW-1]};
  assign fits      = (rem_shift >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= NumW'(DivNum);
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[NumW-2:0], fits};
      rem_q <= fits ? (rem_shift - dvs_q) : rem_shift;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the APU tone register mixer unit.
module tb;
  import apu_trm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWrites = 850;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 40;

  // Result word as it leaves the master port, highest field first.
  typedef struct packed {
    logic [1:0]       pad;
    logic [VolW-1:0]  tri_vol;
    logic [VolW-1:0]  sq2_vol;
    logic [VolW-1:0]  sq1_vol;
    logic [FreqW-1:0] tri_freq;
    logic [FreqW-1:0] sq2_freq;
    logic [FreqW-1:0] sq1_freq;
  } tone_result_t;

  class tone_scoreboard;
    logic [7:0]       per_lo[3];
    logic [2:0]       per_hi[3];
    logic [FreqW-1:0] freq[3];
    logic [VolW-1:0]  vol[3];
    tone_result_t     pending_q[$];
    int unsigned      writes;
    int unsigned      high_writes;
    int unsigned      results;
    int unsigned      errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        per_lo[i] = '0;
        per_hi[i] = '0;
        freq[i]   = '0;
        vol[i]    = VolOff;
      end
      writes      = 0;
      high_writes = 0;
      results     = 0;
      errors      = 0;
    endfunction

    function logic [FreqW-1:0] tone_of(int ch);
      int unsigned period;
      int unsigned hz;
      period = 32'({per_hi[ch], per_lo[ch]});
      hz = CpuClockHz / (16 * (period + 1));
      if (hz > 32'(FreqCapHz)) hz = 32'(FreqCapHz);
      return FreqW'(hz);
    endfunction

    function void note_write(logic [15:0] addr, logic [7:0] data);
      tone_result_t want;
      writes++;
      case (addr)
        AddrSq1Ctrl: vol[ChSq1] = (data[3:0] != 4'd0) ? VolOn : VolOff;
        AddrSq2Ctrl: vol[ChSq2] = (data[3:0] != 4'd0) ? VolOn : VolOff;
        AddrTriCtrl: vol[ChTri] = data[0] ? VolOn : VolOff;
        AddrSq1Low:  per_lo[ChSq1] = data;
        AddrSq2Low:  per_lo[ChSq2] = data;
        AddrTriLow:  per_lo[ChTri] = data;
        AddrSq1High: begin
          per_hi[ChSq1] = data[2:0];
          freq[ChSq1]   = tone_of(ChSq1);
          high_writes++;
        end
        AddrSq2High: begin
          per_hi[ChSq2] = data[2:0];
          freq[ChSq2]   = tone_of(ChSq2);
          high_writes++;
        end
        AddrTriHigh: begin
          per_hi[ChTri] = data[2:0];
          freq[ChTri]   = tone_of(ChTri);
          vol[ChTri]    = (freq[ChTri] < TriMinHz) ? VolOff : VolTriTone;
          high_writes++;
        end
        AddrEnable: begin
          for (int i = 0; i < 3; i++) begin
            if (!data[i]) vol[i] = VolOff;
          end
        end
        default: ;
      endcase
      want.pad      = '0;
      want.sq1_freq = freq[ChSq1];
      want.sq2_freq = freq[ChSq2];
      want.tri_freq = freq[ChTri];
      want.sq1_vol  = vol[ChSq1];
      want.sq2_vol  = vol[ChSq2];
      want.tri_vol  = vol[ChTri];
      pending_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [55:0] raw);
      tone_result_t act;
      tone_result_t want;
      act = raw;
      results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t ns: result %h arrived with no write outstanding", $time, raw);
        return;
      end
      want = pending_q.pop_front();
      compare_field("square1_freq", 32'(want.sq1_freq), 32'(act.sq1_freq));
      compare_field("square2_freq", 32'(want.sq2_freq), 32'(act.sq2_freq));
      compare_field("triangle_freq", 32'(want.tri_freq), 32'(act.tri_freq));
      compare_field("square1_vol", 32'(want.sq1_vol), 32'(act.sq1_vol));
      compare_field("square2_vol", 32'(want.sq2_vol), 32'(act.sq2_vol));
      compare_field("triangle_vol", 32'(want.tri_vol), 32'(act.tri_vol));
      compare_field("pad bits", 32'(want.pad), 32'(act.pad));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [15:0] bus_address, [23:16] write_data
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [13:0] square1_freq, [27:14] square2_freq, [41:28] triangle_freq,
  // [45:42] square1_vol, [49:46] square2_vol, [53:50] triangle_vol, [55:54] zero
  logic [55:0] m_axis_tdata_o;

  tone_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    burst_left = 0;

  apu_tone_register_mixer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, sb.pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // The receiver switches between randomly chosen stall styles.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= stall_phase[2];
    endcase
  end

  // Sends one write; bursts of back-to-back transactions are separated by random gaps.
  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {data, addr};
    burst_left--;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_write(addr, data);
  endtask

  function automatic logic [15:0] pick_address();
    logic [15:0] decoded[10];
    int unsigned roll;
    decoded = '{AddrSq1Ctrl, AddrSq1Low, AddrSq1High, AddrSq2Ctrl, AddrSq2Low,
                AddrSq2High, AddrTriCtrl, AddrTriLow, AddrTriHigh, AddrEnable};
    roll = $urandom_range(0, 99);
    if (roll < 75) return decoded[$urandom_range(0, 9)];
    if (roll < 87) return 16'h4000 + 16'($urandom_range(0, 31));
    return 16'($urandom);
  endfunction

  initial begin
    logic [23:0] directed[$];
    logic [15:0] addr;
    logic [7:0]  data;

    directed = '{
      {8'h0F, AddrSq1Ctrl}, {8'hF0, AddrSq1Ctrl}, {8'h01, AddrSq1Ctrl},
      // Period zero saturates; the upper data bits of the high write are ignored.
      {8'h00, AddrSq1Low}, {8'hF8, AddrSq1High},
      {8'h08, AddrSq2Ctrl}, {8'hFF, AddrSq2Low}, {8'h07, AddrSq2High},
      {8'h01, AddrTriCtrl}, {8'hFE, AddrTriCtrl},
      // Triangle periods on either side of the 100 Hz volume threshold.
      {8'h5D, AddrTriLow}, {8'h04, AddrTriHigh},
      {8'h5E, AddrTriLow}, {8'hFC, AddrTriHigh},
      // Longest period that still saturates, then the first one below the cap.
      {8'h08, AddrSq1Low}, {8'h00, AddrSq1High},
      {8'h09, AddrSq1Low}, {8'h00, AddrSq1High},
      {8'h05, AddrEnable}, {8'hFF, AddrTriCtrl}, {8'hFF, AddrSq2Ctrl},
      {8'hF8, AddrEnable},
      {8'hFF, 16'h0000}, {8'h00, 16'hFFFF}, {8'hFF, 16'h4001}, {8'h07, 16'h4014},
      {8'hFF, 16'h4016}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_write(directed[i][15:0], directed[i][23:16]);

    for (int n = 0; n < RandomWrites; n++) begin
      addr = pick_address();
      data = 8'($urandom);
      send_write(addr, data);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.pending_q.size() != 0) begin
      sb.errors++;
      $display("%0t ns: %0d expected results never arrived", $time, sb.pending_q.size());
    end

    $display("Run covered %0d register writes, %0d of them period high writes, and %0d results,",
             sb.writes, sb.high_writes, sb.results);
    $display("spanning all decoded registers, undecoded addresses and random stalls on both sides.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/apu_trm_pkg.sv
hw/rtl/apu_trm_divider.sv
hw/rtl/apu_tone_register_mixer_unit.sv
sim/tb.sv
